FILE: sv/rmst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

	localparam int LEAVES = 1024;
	localparam int LVL_W = $clog2(LEAVES);
	localparam int NA_W = LVL_W + 1;
	localparam int BW = NA_W + 1;
	localparam int DEPTH = 2 * LEAVES;
	localparam int IDX_W = 10;
	localparam int DATA_W = 32;
	localparam int SIZE_W = 11;
	localparam int CMP_W = ((IDX_W > NA_W) ? IDX_W : NA_W) + 1;
	localparam int ADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
	localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [ADDR_W-3:0] REG_SIZE = '0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WLEAF,
		ST_WCLIMB,
		ST_QSETUP,
		ST_QLOOP,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                     op;
		logic [IDX_W-1:0]         left;
		logic [IDX_W-1:0]         right;
		logic signed [DATA_W-1:0] value;
		logic [SIZE_W-1:0]        size;
	} req_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/rmst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rmst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

FILE: sv/rmst_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module rmst_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire rmst_pkg::req_t req,
	output logic                ready,
	output rmst_pkg::res_t      res,
	input  wire logic           res_ready
);

	import rmst_pkg::*;

	state_t state_q, state_d;
	req_t req_q;

	logic [NA_W-1:0] clr_q;
	logic [NA_W-1:0] k_q;
	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] acc_q;
	logic [BW-1:0] a_q, b_q;
	logic pend_a_q, pend_b_q;

	logic we;
	logic [NA_W-1:0] waddr, raddr_a, raddr_b;
	logic signed [DATA_W-1:0] wdata;
	logic signed [DATA_W-1:0] rdata_a, rdata_b;

	logic [NA_W-1:0] leaf_addr, parent;
	logic write_ok;
	logic signed [DATA_W-1:0] sib_min, fold_a, fold_b;
	logic loop_run;
	logic [BW-1:0] b_dec;
	logic [SIZE_W-1:0] used, hi_c;
	logic q_empty;

	rmst_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign leaf_addr = NA_W'(LEAVES) + NA_W'(req_q.left);
	assign write_ok  = CMP_W'(req_q.left) < CMP_W'(LEAVES);
	assign parent    = k_q >> 1;
	assign sib_min   = (rdata_a < cur_q) ? rdata_a : cur_q;
	assign fold_a    = (pend_a_q && (rdata_a < acc_q)) ? rdata_a : acc_q;
	assign fold_b    = (pend_b_q && (rdata_b < fold_a)) ? rdata_b : fold_a;
	assign loop_run  = a_q < b_q;
	assign b_dec     = b_q - BW'(1);

	// clamp the range to the elements in use
	assign used    = (req_q.size > SIZE_W'(LEAVES)) ? SIZE_W'(LEAVES) : req_q.size;
	assign hi_c    = (SIZE_W'(req_q.right) >= used) ? used - SIZE_W'(1)
	                                                 : SIZE_W'(req_q.right);
	assign q_empty = (used == '0) || (SIZE_W'(req_q.left) > hi_c);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = (req.op == OP_WRITE) ? ST_WLEAF : ST_QSETUP;
			end
			ST_WLEAF: begin
				state_d = write_ok ? ST_WCLIMB : ST_IDLE;
			end
			ST_WCLIMB: begin
				if (parent == NA_W'(1)) state_d = ST_IDLE;
			end
			ST_QSETUP: begin
				state_d = q_empty ? ST_RESULT : ST_QLOOP;
			end
			ST_QLOOP: begin
				if (!loop_run) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we      = 1'b0;
		waddr   = k_q;
		wdata   = cur_q;
		raddr_a = a_q[NA_W-1:0];
		raddr_b = b_dec[NA_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = INT_MAX;
			end
			ST_WLEAF: begin
				we      = write_ok;
				waddr   = leaf_addr;
				wdata   = req_q.value;
				raddr_a = leaf_addr ^ NA_W'(1);
			end
			ST_WCLIMB: begin
				we      = 1'b1;
				waddr   = parent;
				wdata   = sib_min;
				raddr_a = parent ^ NA_W'(1);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign ready     = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_RESULT);
	assign res.value = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + NA_W'(1);
			if (state_q == ST_QLOOP) begin
				pend_a_q <= loop_run & a_q[0];
				pend_b_q <= loop_run & b_q[0];
			end else begin
				pend_a_q <= 1'b0;
				pend_b_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) req_q <= req;
			end
			ST_WLEAF: begin
				k_q   <= leaf_addr;
				cur_q <= req_q.value;
			end
			ST_WCLIMB: begin
				k_q   <= parent;
				cur_q <= sib_min;
			end
			ST_QSETUP: begin
				a_q   <= BW'(req_q.left) + BW'(LEAVES);
				b_q   <= BW'(hi_c) + BW'(LEAVES) + BW'(1);
				acc_q <= INT_MAX;
			end
			ST_QLOOP: begin
				acc_q <= fold_b;
				if (loop_run) begin
					a_q <= (a_q + BW'(a_q[0])) >> 1;
					b_q <= (b_q - BW'(b_q[0])) >> 1;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/range_min_segment_tree_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    opcode, index_left, index_right, value_in
// out      out_valid / out_ready  min_value
// cfg      APB psel/penable       paddr, pwdata, prdata (size_in_use at 0x0)
//
// A write stores the leaf, then one parent per level, each fed by a
// sibling read from the node RAM issued the cycle before.
// A query runs one setup step, then passes of the two-port bottom-up walk
// (none for an empty range), then one step to hand over the result.
// After reset the node RAM is cleared one entry a cycle, all 2048, with in_ready low.
// A result held in the output register stalls the next query and all after it.

module range_min_segment_tree_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           opcode,
	input  wire logic [rmst_pkg::IDX_W-1:0]     index_left,
	input  wire logic [rmst_pkg::IDX_W-1:0]     index_right,
	input  wire logic signed [rmst_pkg::DATA_W-1:0] value_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [rmst_pkg::DATA_W-1:0]  min_value,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rmst_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rmst_pkg::PDATA_W-1:0]   pwdata,
	output logic [rmst_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	import rmst_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic out_valid_q;
	logic signed [DATA_W-1:0] min_value_q;
	logic eng_ready, res_ready, start, cfg_wr;
	req_t req;
	res_t res;

	assign req.op    = opcode;
	assign req.left  = index_left;
	assign req.right = index_right;
	assign req.value = value_in;
	assign req.size  = size_q;

	assign in_ready  = eng_ready;
	assign start     = in_valid & eng_ready;
	assign res_ready = !out_valid_q || out_ready;

	rmst_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.ready    (eng_ready),
		.res      (res),
		.res_ready(res_ready)
	);

	assign cfg_wr = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_SIZE);
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_SIZE) ? PDATA_W'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) size_q <= pwdata[SIZE_W-1:0];
			if (res.valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) min_value_q <= res.value;
	end

	assign out_valid = out_valid_q;
	assign min_value = min_value_q;

	a_res_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !in_ready)
		else $error("result pending while engine idle");

	a_write_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		(start && opcode == OP_WRITE) |=> !res.valid)
		else $error("write item produced a result");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(res.valid))
		else $error("output item without engine result");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (size_q == $past(pwdata[SIZE_W-1:0])))
		else $error("size register not updated");

endmodule

`default_nettype wire

FILE: dv/range_min_segment_tree_chk.sv
`timescale 1ns / 1ps

module range_min_segment_tree_chk import rmst_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_ready,
	input  wire logic                     opcode,
	input  wire logic [IDX_W-1:0]         index_left,
	input  wire logic [IDX_W-1:0]         index_right,
	input  wire logic signed [DATA_W-1:0] value_in,
	input  wire logic                     out_valid,
	input  wire logic                     out_ready,
	input  wire logic signed [DATA_W-1:0] min_value,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [ADDR_W-1:0]        paddr,
	input  wire logic [PDATA_W-1:0]       pwdata,
	input  wire logic                     pready,
	output int                            fail_count,
	output int                            results_pending
);

	logic signed [DATA_W-1:0] node_min [DEPTH];
	logic [SIZE_W-1:0]        size_reg;
	logic signed [DATA_W-1:0] expected_min [$];
	int                       mismatches;

	task automatic report(input string msg);
		$display("[%0t] %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void store_element(input int unsigned idx,
			input logic signed [DATA_W-1:0] val);
		int unsigned k;
		k = LEAVES + idx;
		node_min[k] = val;
		for (k = k >> 1; k >= 1; k = k >> 1)
			node_min[k] = (node_min[2*k] < node_min[2*k+1]) ? node_min[2*k] : node_min[2*k+1];
	endfunction

	function automatic logic signed [DATA_W-1:0] range_minimum(input int unsigned lo,
			input int unsigned hi);
		int unsigned used, a, b;
		logic signed [DATA_W-1:0] best;
		best = INT_MAX;
		used = 32'(size_reg);
		if (used > LEAVES)
			used = LEAVES;
		if (used == 0)
			return best;
		if (hi > used - 1)
			hi = used - 1;
		if (lo > hi)
			return best;
		a = lo + LEAVES;
		b = hi + LEAVES + 1;
		while (a < b) begin
			if (a[0]) begin
				if (node_min[a] < best)
					best = node_min[a];
				a++;
			end
			if (b[0]) begin
				b--;
				if (node_min[b] < best)
					best = node_min[b];
			end
			a = a >> 1;
			b = b >> 1;
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [DATA_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				node_min[i] = INT_MAX;
			size_reg = SIZE_RESET;
			expected_min.delete();
			mismatches = 0;
			fail_count <= 0;
			results_pending <= 0;
		end else begin
			// results first: a query accepted this edge cannot be answered at it
			if (out_valid && out_ready) begin
				if (expected_min.size() == 0) begin
					report($sformatf("unexpected result min_value %0d", min_value));
				end else begin
					want = expected_min.pop_front();
					if (min_value !== want)
						report($sformatf("min_value %0d, want %0d", min_value, want));
				end
			end
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_SIZE)
				size_reg = pwdata[SIZE_W-1:0];
			if (in_valid && in_ready) begin
				if (opcode == OP_WRITE)
					store_element(32'(index_left), value_in);
				else
					expected_min.push_back(range_minimum(32'(index_left),
						32'(index_right)));
			end
			fail_count <= mismatches;
			results_pending <= expected_min.size();
		end
	end

endmodule

FILE: dv/range_min_segment_tree_top_tb.sv
`timescale 1ns / 1ps

module range_min_segment_tree_top_tb;
	import rmst_pkg::*;

	localparam int IDX_MAX = LEAVES - 1;
	localparam int ITEMS_PER_PHASE = 155;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 600;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
	localparam logic [ADDR_W-1:0] SIZE_ADDR = {REG_SIZE, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_REG_ADDR = SIZE_ADDR + ADDR_W'(4);

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     opcode = OP_WRITE;
	logic [IDX_W-1:0]         index_left = '0;
	logic [IDX_W-1:0]         index_right = '0;
	logic signed [DATA_W-1:0] value_in = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] min_value;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	int                       fail_count;
	int                       results_pending;

	int          send_idle = 0;
	int          recv_stall = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int unsigned cur_size = 32'(SIZE_RESET);
	int unsigned cycle_count = 0;

	range_min_segment_tree_top u_top (.*);

	range_min_segment_tree_chk u_chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_item(input logic op, input logic [IDX_W-1:0] lo,
			input logic [IDX_W-1:0] hi, input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		index_left <= lo;
		index_right <= hi;
		value_in <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic put_value(input int unsigned idx, input logic signed [DATA_W-1:0] val);
		send_item(OP_WRITE, IDX_W'(idx), IDX_W'($urandom_range(IDX_MAX)), val);
	endtask

	task automatic ask_min(input int unsigned lo, input int unsigned hi);
		send_item(OP_QUERY, IDX_W'(lo), IDX_W'(hi), $urandom);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [ADDR_W-1:0] addr, input int unsigned val);
		logic [PDATA_W-1:0] data;
		data = $urandom;
		data[SIZE_W-1:0] = SIZE_W'(val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_size(input int unsigned size);
		settle();
		cfg_write(SIZE_ADDR, size);
		cur_size = size;
	endtask

	task automatic random_item(input int unsigned used);
		int unsigned lo, hi;
		logic signed [DATA_W-1:0] val;
		lo = ($urandom_range(9) == 0) ? $urandom_range(IDX_MAX) : $urandom_range(used - 1);
		case ($urandom_range(9))
			0: val = INT_MIN;
			1: val = INT_MAX;
			2: val = int'($urandom_range(20)) - 10;
			default: val = $urandom;
		endcase
		if ($urandom_range(99) < 45) begin
			put_value(lo, val);
		end else begin
			case ($urandom_range(9))
				0: hi = $urandom_range(IDX_MAX);
				1: hi = (lo == 0) ? 0 : $urandom_range(lo - 1);
				2: hi = lo;
				3, 4: begin
					hi = lo + $urandom_range(15);
					if (hi > IDX_MAX)
						hi = IDX_MAX;
				end
				default: hi = $urandom_range(used - 1, lo);
			endcase
			ask_min(lo, hi);
		end
	endtask

	initial begin
		int phase_idle[6];
		int phase_stall[6];
		int unsigned used;
		phase_idle = '{0, 75, 0, 16, 0, 25};
		phase_stall = '{0, 0, 75, 16, 0, 10};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset size, unwritten leaves, value extremes
		ask_min(0, IDX_MAX);
		put_value(0, 5);
		put_value(IDX_MAX, INT_MIN);
		put_value(512, -1);
		put_value(511, INT_MAX);
		put_value(1, 0);
		ask_min(0, IDX_MAX);
		ask_min(0, IDX_MAX - 1);
		ask_min(IDX_MAX, IDX_MAX);
		ask_min(0, 0);
		ask_min(600, 100);
		ask_min(511, 511);
		put_value(IDX_MAX, 1);
		ask_min(513, IDX_MAX);
		ask_min(1, 1);
		apply_size(0);
		ask_min(0, IDX_MAX);
		apply_size(2047);
		ask_min(0, IDX_MAX);
		settle();
		cfg_write(SPARE_REG_ADDR, 3);
		ask_min(0, IDX_MAX);
		apply_size(1);
		ask_min(0, IDX_MAX);
		ask_min(1, 5);
		apply_size(8);
		put_value(900, INT_MIN);
		ask_min(0, IDX_MAX);
		put_value(7, -7);
		ask_min(7, 500);
		apply_size(LEAVES);
		ask_min(800, IDX_MAX);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_size(LEAVES);
				1: apply_size(2047);
				2: apply_size(1);
				3: apply_size($urandom_range(64, 2));
				4: apply_size($urandom_range(LEAVES - 1, 65));
				default: apply_size(LEAVES);
			endcase
			send_idle = phase_idle[p];
			recv_stall = phase_stall[p];
			if (p == 4)
				hold_req++;
			used = (cur_size > LEAVES) ? LEAVES : cur_size;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				random_item(used);
		end

		send_idle = 0;
		recv_stall = 0;
		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
